// ===== rtl/core/ssmm_pkg.sv =====
// shared types and constants for the sample set min/median core
`timescale 1ns / 1ps
package ssmm_pkg;

  // store capacity and derived widths
  localparam int MAX_SAMPLES = 256;
  localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SAMPLE_W    = 32;
  localparam int BIT_W       = $clog2(SAMPLE_W);
  localparam int MEDIAN_W    = SAMPLE_W + 1;
  localparam int SCOUNT_W    = 9;

  // input item
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [SAMPLE_W-1:0] min_value;
    logic [MEDIAN_W-1:0] median_value;
    logic [SCOUNT_W-1:0] sample_count;
    logic                overflow;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // store the input transfer
    logic sel_init;  // start first selection pass
    logic rd;        // read store at scan address, advance address
    logic decide;    // settle one bit of the selected value
    logic pass2;     // start second selection (even count)
    logic emit;      // load result register, clear set state
  } ssmm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last; // scan address is the last kept entry
    logic bit_zero;  // current bit is the lsb
    logic even;      // kept count is even
    logic in_pass2;  // second selection running
    logic out_busy;  // result register full and not taken this cycle
  } ssmm_sts_t;

endpackage

// ===== rtl/core/ssmm_dp.sv =====
// datapath: sample store, running minimum, bitwise rank selection, result register
`timescale 1ns / 1ps
module ssmm_dp
  import ssmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ssmm_cmd_t cmd,
  output ssmm_sts_t sts,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic                drop_r, drop_nxt;

  logic [ADDR_W-1:0]   addr_r;
  logic [BIT_W-1:0]    bit_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    rank_r;
  logic [SAMPLE_W-1:0] prefix_r;
  logic [SAMPLE_W-1:0] val_a_r;
  logic                pass2_r;

  logic                room;
  logic [SAMPLE_W-1:0] hi_mask;
  logic                match;
  logic [CNT_W-1:0]    last_idx;

  logic                out_valid_r;
  out_item_t           out_data_r;

  assign room = (count_r < CNT_W'(MAX_SAMPLES));

  // set bookkeeping on each transfer
  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    drop_nxt  = drop_r;
    if (cmd.load) begin
      if (room) begin
        count_nxt = count_r + 1'b1;
        if (in_data.sample < min_r) begin
          min_nxt = in_data.sample;
        end
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.emit) begin
      count_nxt = '0;
      min_nxt   = '1;
      drop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '1;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // sample store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      store_mem[count_r[ADDR_W-1:0]] <= in_data.sample;
    end
    if (cmd.rd) begin
      rd_data_r <= store_mem[addr_r];
    end
  end

  // element counts toward this bit if its upper bits equal the prefix and this bit is 0
  assign hi_mask  = ({SAMPLE_W{1'b1}} << bit_r) << 1;
  assign match    = (((rd_data_r ^ prefix_r) & hi_mask) == '0) && !rd_data_r[bit_r];
  assign last_idx = count_r - 1'b1;

  // selection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      pass2_r  <= 1'b0;
      addr_r   <= '0;
      bit_r    <= '0;
      cnt_r    <= '0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.sel_init || cmd.pass2) begin
        addr_r  <= '0;
        bit_r   <= BIT_W'(SAMPLE_W - 1);
        cnt_r   <= '0;
        pass2_r <= cmd.pass2;
      end else if (cmd.decide) begin
        addr_r <= '0;
        bit_r  <= bit_r - 1'b1;
        cnt_r  <= '0;
      end else begin
        if (cmd.rd) begin
          addr_r <= addr_r + 1'b1;
        end
        if (rd_vld_r && match) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // prefix and remaining rank
  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      prefix_r <= '0;
      rank_r   <= count_nxt[0] ? (count_nxt >> 1) : ((count_nxt >> 1) - 1'b1);
    end else if (cmd.pass2) begin
      val_a_r  <= prefix_r;
      prefix_r <= '0;
      rank_r   <= count_r >> 1;
    end else if (cmd.decide) begin
      if (rank_r >= cnt_r) begin
        prefix_r[bit_r] <= 1'b1;
        rank_r          <= rank_r - cnt_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.min_value    <= min_r;
      out_data_r.median_value <= count_r[0] ? {prefix_r, 1'b0}
                                            : ({1'b0, val_a_r} + {1'b0, prefix_r});
      out_data_r.sample_count <= SCOUNT_W'(count_r);
      out_data_r.overflow     <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status back to the controller
  assign sts.addr_last = ({{(CNT_W-ADDR_W){1'b0}}, addr_r} == last_idx);
  assign sts.bit_zero  = (bit_r == '0);
  assign sts.even      = !count_r[0];
  assign sts.in_pass2  = pass2_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

endmodule

// ===== rtl/core/ssmm_ctrl.sv =====
// controller: load, scan passes per bit, second pass for even sets, result handoff
`timescale 1ns / 1ps
module ssmm_ctrl
  import ssmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  ssmm_sts_t sts,
  output ssmm_cmd_t cmd
);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       xfer;

  assign in_ready = (state_r == ST_LOAD);
  assign xfer     = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        cmd.load = xfer;
        if (xfer && in_last) begin
          cmd.sel_init = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.addr_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.bit_zero ? ST_FIN : ST_SCAN;
      end
      ST_FIN: begin
        if (sts.even && !sts.in_pass2) begin
          cmd.pass2 = 1'b1;
          state_nxt = ST_SCAN;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/sample_set_min_median_core.sv =====
// top level: minimum and median of a set of Q24.8 timing samples
//
//  channel  signals                          direction  contents
//  in       in_valid, in_ready, in_data      input      in_item_t: sample, last_sample
//  out      out_valid, out_ready, out_data   output     out_item_t: min, median, count, overflow
//
// samples load one per cycle while the core is loading; the store and running minimum
// update on each transfer. after the closing transfer the median is found msb first, one
// read pass per bit over the n kept entries through the single store read port; for even
// sets a second selection runs before the result register loads
// no input transfer is taken during selection or while a finished result waits to load;
// a waiting result only holds off the next result. synchronous active-low reset, no clear pass
`timescale 1ns / 1ps
module sample_set_min_median_core
  import ssmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ssmm_cmd_t cmd;
  ssmm_sts_t sts;

  // sequencing
  ssmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_sample),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, selection and result register
  ssmm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tb_sample_set_min_median_core.sv =====
// testbench for the sample set min/median core: sample sets in, checked statistics out
`timescale 1ns / 1ps
module tb_sample_set_min_median_core
  import ssmm_pkg::*;
();

  // a set holds up to 256 samples; the cycle limit is far above the slowest correct run,
  // stalls included
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS  = 332;
  localparam int unsigned NUM_DIRECTED = 22;

  // expected min/median per set, kept from the accepted sample transfers
  class set_stats_tracker;
    logic [SAMPLE_W-1:0] kept [MAX_SAMPLES];
    int unsigned         kept_count;
    logic [SAMPLE_W-1:0] low_mark;
    bit                  dropped;
    out_item_t           pending_stats [$];
    int unsigned         mismatches;

    function new();
      mismatches = 0;
      start_set();
    endfunction

    function void start_set();
      kept_count = 0;
      low_mark   = '1;
      dropped    = 1'b0;
    endfunction

    // one accepted sample; a closing sample queues the set's statistics
    function void take_sample(in_item_t item);
      logic [SAMPLE_W-1:0] order [MAX_SAMPLES];
      logic [SAMPLE_W-1:0] v;
      out_item_t           stats;
      int                  i;
      int                  j;
      if (kept_count < MAX_SAMPLES) begin
        kept[kept_count] = item.sample;
        kept_count++;
        if (item.sample < low_mark) low_mark = item.sample;
      end else begin
        dropped = 1'b1;
      end
      if (!item.last_sample) return;

      // insertion sort of the kept samples
      for (i = 0; i < kept_count; i++) order[i] = kept[i];
      for (i = 1; i < kept_count; i++) begin
        v = order[i];
        j = i;
        while (j > 0 && order[j-1] > v) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end

      stats.min_value = low_mark;
      if (kept_count % 2 == 1) begin
        stats.median_value = {order[kept_count/2], 1'b0};
      end else begin
        stats.median_value = {1'b0, order[kept_count/2 - 1]} + {1'b0, order[kept_count/2]};
      end
      stats.sample_count = SCOUNT_W'(kept_count);
      stats.overflow     = dropped;
      pending_stats.insert(pending_stats.size(), stats);
      start_set();
    endfunction

    function void report_field(string field, logic [63:0] exp_val, logic [63:0] got_val);
      if (exp_val !== got_val) begin
        mismatches++;
        $display("%0t: %s expected %h actual %h", $time, field, exp_val, got_val);
      end
    endfunction

    // one accepted result against the oldest expected set
    function void check_stats(out_item_t got);
      out_item_t exp_stats;
      if (pending_stats.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual %h", $time, got);
        return;
      end
      exp_stats = pending_stats.pop_front();
      report_field("min_value", exp_stats.min_value, got.min_value);
      report_field("median_value", exp_stats.median_value, got.median_value);
      report_field("sample_count", exp_stats.sample_count, got.sample_count);
      report_field("overflow", exp_stats.overflow, got.overflow);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  set_stats_tracker sb;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      cycle_count = 0;

  // directed sets: {last_sample, sample}
  logic [SAMPLE_W:0] directed_items [NUM_DIRECTED] = '{
    {1'b1, 32'h0000_0000},
    {1'b1, 32'hFFFF_FFFF},
    {1'b0, 32'hFFFF_FFFF}, {1'b1, 32'hFFFF_FFFF},
    {1'b0, 32'h0000_0005}, {1'b0, 32'h0000_0000}, {1'b1, 32'h0000_0009},
    {1'b0, 32'h0000_0007}, {1'b0, 32'h0000_0003}, {1'b0, 32'h0000_0003},
    {1'b1, 32'h0000_0001},
    {1'b0, 32'h0000_0001}, {1'b1, 32'h0000_0002},
    {1'b0, 32'h8000_0000}, {1'b0, 32'h7FFF_FFFF}, {1'b0, 32'h0000_0000},
    {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h1234_5678}, {1'b1, 32'hAAAA_AAAA},
    {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'hFFFF_FFFE}, {1'b1, 32'hFFFF_FFFD}
  };

  sample_set_min_median_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watch both channels for transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_sample(in_data);
      if (out_valid && out_ready) sb.check_stats(out_data);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // present one sample and hold it until the transfer
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic closing);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= '{sample: value, last_sample: closing};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // extremes, duplicates and plain random values
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SAMPLE_W'($urandom_range(15));
      4:       return '1 - SAMPLE_W'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned set_len;
    int unsigned k;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed sets
    for (k = 0; k < NUM_DIRECTED; k++) begin
      send_sample(directed_items[k][SAMPLE_W-1:0], directed_items[k][SAMPLE_W]);
    end

    // random sets under four idle profiles
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // one full store, one dropped closing sample, one dropped run; else small sets
        if (sent == 0 && phase == 0) begin
          set_len = MAX_SAMPLES;
        end else if (sent == 0 && phase == 1) begin
          set_len = MAX_SAMPLES + 1;
        end else if (sent == 0 && phase == 2) begin
          set_len = MAX_SAMPLES + $urandom_range(2, 40);
        end else if ($urandom_range(7) == 0) begin
          set_len = $urandom_range(13, 40);
        end else begin
          set_len = $urandom_range(1, 12);
        end
        for (k = 0; k < set_len; k++) begin
          send_sample(pick_sample(), k == set_len - 1);
        end
        sent += set_len;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain the outstanding results, then watch for stray ones
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
